// ----- design/rse_pkg.sv -----
// Shared codes, register indexes and types for the RISC-V subset execute block.
package rse_pkg;

   // Item commands
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_EXECUTE = 1'b1;

   // Major opcodes
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_IMM    = 7'h13;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JAL    = 7'h6f;

   // funct3 codes
   localparam logic [2:0] F3_ADD = 3'b000;
   localparam logic [2:0] F3_SLL = 3'b001;
   localparam logic [2:0] F3_SRL = 3'b101;
   localparam logic [2:0] F3_AND = 3'b111;
   localparam logic [2:0] F3_BEQ = 3'b000;
   localparam logic [2:0] F3_BNE = 3'b001;
   localparam logic [2:0] F3_BLT = 3'b100;
   localparam logic [2:0] F3_BGE = 3'b101;

   // Architectural register numbers with special handling
   localparam logic [4:0] REG_ZERO = 5'd0;
   localparam logic [4:0] REG_RA   = 5'd1;
   localparam logic [4:0] REG_A0   = 5'd10;
   localparam logic [4:0] REG_A1   = 5'd11;
   localparam logic [4:0] REG_A2   = 5'd12;
   localparam logic [4:0] REG_A3   = 5'd13;

   // Configuration register indexes
   localparam int CFG_INDEX_WIDTH = 3;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_START_ADDRESS = 3'd0;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STOP_ADDRESS  = 3'd1;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ARG_ZERO      = 3'd2;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ARG_ONE       = 3'd3;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ARG_TWO       = 3'd4;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ARG_THREE     = 3'd5;

   // Result status
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   // Decode/execute control handed to the state update logic
   typedef struct packed {
      logic       start;
      logic       bad;
      logic       write;
      logic       mul_op;
      logic [4:0] rd;
   } exec_flags_type;

endpackage

// ----- design/rse_if.sv -----
// Valid/ready channel interfaces for instruction items and execute results.
interface rse_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] instr_word;

   modport source (output valid, cmd, instr_word, input ready);
   modport sink (input valid, cmd, instr_word, output ready);
endinterface

interface rse_rsp_if #(
   parameter int XLEN = 64
);
   logic            valid;
   logic            ready;
   logic [XLEN-1:0] next_pc;
   logic            halted;
   logic            reg_written;
   logic [4:0]      written_reg;
   logic [XLEN-1:0] written_value;
   logic [XLEN-1:0] return_value;
   logic            status;

   modport source (output valid, next_pc, halted, reg_written, written_reg, written_value,
                   return_value, status, input ready);
   modport sink (input valid, next_pc, halted, reg_written, written_reg, written_value,
                 return_value, status, output ready);
endinterface

// ----- design/rse_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module rse_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ----- design/rse_mul.sv -----
// Registered multiplier giving the low XLEN bits of a product from half-width parts.
module rse_mul #(
   parameter int XLEN = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            clear,
   input  logic [XLEN-1:0] op_a,
   input  logic [XLEN-1:0] op_b,
   output logic            done,
   output logic [XLEN-1:0] product
);

   localparam int LO = (XLEN + 1) / 2;
   localparam int HI = XLEN - LO;

   logic [2*LO-1:0] low_full;
   logic [HI-1:0]   cross_in;
   logic [XLEN-1:0] low_ff;
   logic [HI-1:0]   cross_ff;
   logic            done_ff;
   logic            done_in;

   // Cross terms only matter modulo 2^HI once shifted up by LO
   assign low_full = op_a[LO-1:0] * op_b[LO-1:0];
   assign cross_in = op_a[HI-1:0] * op_b[XLEN-1:LO] + op_a[XLEN-1:LO] * op_b[HI-1:0];

   always_comb begin
      done_in = done_ff;
      if (clear) begin
         done_in = 1'b0;
      end else if (start) begin
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         low_ff   <= low_full[XLEN-1:0];
         cross_ff <= cross_in;
      end
   end

   assign done    = done_ff;
   assign product = low_ff + {cross_ff, {LO{1'b0}}};

endmodule

// ----- design/rse_exec.sv -----
// Decode and execute of one instruction word against its operands and the pc.
module rse_exec #(
   parameter int XLEN      = 64,
   parameter int REG_COUNT = 32
) (
   input  logic                    cmd,
   input  logic [31:0]             instr_word,
   input  logic [XLEN-1:0]         pc,
   input  logic [XLEN-1:0]         start_pc,
   input  logic [XLEN-1:0]         op_a,
   input  logic [XLEN-1:0]         op_b,
   input  logic [XLEN-1:0]         product,
   output logic [XLEN-1:0]         next_pc,
   output logic [XLEN-1:0]         wr_value,
   output rse_pkg::exec_flags_type flags
);

   localparam int SHW = (XLEN > 32) ? 6 : 5;
   localparam logic [5:0] RC6 = 6'(REG_COUNT);

   logic [6:0]      opcode;
   logic [4:0]      rd;
   logic [4:0]      rs1;
   logic [4:0]      rs2;
   logic [2:0]      f3;
   logic [XLEN-1:0] imm_i;
   logic [XLEN-1:0] off_b;
   logic [XLEN-1:0] off_j;
   logic [XLEN-1:0] pc_plus4;
   logic [XLEN-1:0] addend;
   logic [XLEN-1:0] sum;
   logic [XLEN-1:0] diff;
   logic [SHW-1:0]  shamt;
   logic [XLEN-1:0] shl;
   logic [XLEN-1:0] shr;
   logic [XLEN-1:0] sra;
   logic            eq;
   logic            lt;
   logic            idx_bad;
   logic            take;
   logic [XLEN-1:0] result;
   logic            write;
   logic            bad;
   logic            mul_op;

   assign opcode = instr_word[6:0];
   assign rd     = instr_word[11:7];
   assign f3     = instr_word[14:12];
   assign rs1    = instr_word[19:15];
   assign rs2    = instr_word[24:20];

   assign imm_i = {{(XLEN-12){instr_word[31]}}, instr_word[31:20]};
   assign off_b = {{(XLEN-13){instr_word[31]}}, instr_word[31], instr_word[7],
                   instr_word[30:25], instr_word[11:8], 1'b0};
   assign off_j = {{(XLEN-21){instr_word[31]}}, instr_word[31], instr_word[19:12],
                   instr_word[20], instr_word[30:21], 1'b0};

   assign pc_plus4 = pc + XLEN'(4);
   assign addend   = (opcode == rse_pkg::OPC_OP) ? op_b : imm_i;
   assign sum      = op_a + addend;
   assign diff     = op_a - op_b;
   assign shamt    = (opcode == rse_pkg::OPC_IMM) ? instr_word[20 +: SHW] : op_b[SHW-1:0];
   assign shl      = op_a << shamt;
   assign shr      = op_a >> shamt;
   assign sra      = $signed(op_a) >>> shamt;
   assign eq       = (op_a == op_b);
   assign lt       = ($signed(op_a) < $signed(op_b));

   // rs2 is only checked for formats that have one
   assign idx_bad = ({1'b0, rd} >= RC6) || ({1'b0, rs1} >= RC6) ||
                    (((opcode == rse_pkg::OPC_OP) || (opcode == rse_pkg::OPC_BRANCH)) &&
                     ({1'b0, rs2} >= RC6));

   always_comb begin
      result  = '0;
      write   = 1'b0;
      bad     = 1'b0;
      mul_op  = 1'b0;
      take    = 1'b0;
      next_pc = pc;
      case (opcode)
         rse_pkg::OPC_OP: begin
            write   = 1'b1;
            next_pc = pc_plus4;
            case (f3)
               rse_pkg::F3_ADD: begin
                  if (instr_word[25]) begin
                     result = product;
                     mul_op = 1'b1;
                  end else if (instr_word[30]) begin
                     result = diff;
                  end else begin
                     result = sum;
                  end
               end
               rse_pkg::F3_SLL: result = shl;
               rse_pkg::F3_SRL: result = instr_word[30] ? sra : shr;
               rse_pkg::F3_AND: result = op_a & op_b;
               default:         bad = 1'b1;
            endcase
         end
         rse_pkg::OPC_IMM: begin
            write   = 1'b1;
            next_pc = pc_plus4;
            case (f3)
               rse_pkg::F3_ADD: result = sum;
               rse_pkg::F3_SLL: result = shl;
               rse_pkg::F3_SRL: result = instr_word[30] ? sra : shr;
               default:         bad = 1'b1;
            endcase
         end
         rse_pkg::OPC_JALR: begin
            write   = 1'b1;
            result  = pc_plus4;
            next_pc = {sum[XLEN-1:1], 1'b0};
            if (f3 != rse_pkg::F3_ADD) begin
               bad = 1'b1;
            end
         end
         rse_pkg::OPC_BRANCH: begin
            case (f3)
               rse_pkg::F3_BEQ: take = eq;
               rse_pkg::F3_BNE: take = !eq;
               rse_pkg::F3_BLT: take = lt;
               rse_pkg::F3_BGE: take = !lt;
               default:         bad = 1'b1;
            endcase
            next_pc = take ? (pc + off_b) : pc_plus4;
         end
         rse_pkg::OPC_JAL: begin
            write   = 1'b1;
            result  = pc_plus4;
            next_pc = pc + off_j;
         end
         default: bad = 1'b1;
      endcase

      if (idx_bad) begin
         bad = 1'b1;
      end
      if (cmd == rse_pkg::CMD_START) begin
         next_pc = start_pc;
         write   = 1'b0;
         bad     = 1'b0;
         mul_op  = 1'b0;
      end
      // Drop the whole effect of a rejected word
      if (bad) begin
         next_pc = pc;
         write   = 1'b0;
      end
      if (rd == rse_pkg::REG_ZERO) begin
         write = 1'b0;
      end

      flags.start  = (cmd == rse_pkg::CMD_START);
      flags.bad    = bad;
      flags.write  = write;
      flags.mul_op = mul_op;
      flags.rd     = write ? rd : rse_pkg::REG_ZERO;
      wr_value     = write ? result : '0;
   end

endmodule

// ----- design/riscv_subset_execute_top.sv -----
// Top level of the RISC-V subset execute block: register file, pc and result stage.
//
// Items enter on req_ch (cmd, instr_word) and each gives one result on rsp_ch;
// both channels transfer when valid and ready are high at a clock edge.
// A start item loads the pc from start_address, ra from stop_address and a0..a3
// from the argument registers; an execute item runs one instruction word at the pc.
// Configuration registers are written through csr_write_en/csr_index/csr_wdata;
// the user must write them only while no item is in flight; the block does not enforce it.
// Each item passes through the execute stage and then the output register.
// Throughput: one item per cycle while no mul item waits and rsp_ch does not stall; a mul item
// waits in the execute stage for the split half-width multiplier. General registers sit
// in a RAM with a registered read, so the write of one item reaches the next item
// through a one-entry bypass; ra and a0..a3 are held in flip-flops.
// Reset clears the pc, every register (through per-entry valid bits), the
// configuration registers and all in-flight items; no clearing pass is needed.
// When rsp_ch stalls, the result holds in the output register, the execute stage
// holds one more item, and req_ch.ready falls once both are full or while a mul item waits.
module riscv_subset_execute_top #(
   parameter int XLEN      = 64,
   parameter int REG_COUNT = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   rse_req_if.sink                             req_ch,
   rse_rsp_if.source                           rsp_ch,
   input  logic                                csr_write_en,
   input  logic [rse_pkg::CFG_INDEX_WIDTH-1:0] csr_index,
   input  logic [XLEN-1:0]                     csr_wdata
);

   localparam int IDXW = $clog2(REG_COUNT);

   // Configuration
   logic [XLEN-1:0]      start_addr_ff;
   logic [XLEN-1:0]      stop_addr_ff;
   logic [3:0][XLEN-1:0] arg_cfg_ff;

   // Architectural state outside the RAM
   logic [XLEN-1:0]      pc_ff;
   logic [XLEN-1:0]      pc_in;
   logic [XLEN-1:0]      ra_ff;
   logic [XLEN-1:0]      ra_in;
   logic [3:0][XLEN-1:0] arg_reg_ff;
   logic [3:0][XLEN-1:0] arg_reg_in;
   logic [REG_COUNT-1:0] reg_valid_ff;
   logic [REG_COUNT-1:0] reg_valid_in;

   // Bypass of the write made at the edge the current operands were read
   logic                 fwd_valid_ff;
   logic                 fwd_valid_in;
   logic [4:0]           fwd_idx_ff;
   logic [XLEN-1:0]      fwd_data_ff;

   // Execute stage
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic                 s1_cmd_ff;
   logic [31:0]          s1_instr_ff;
   logic                 s1_fire;
   logic                 req_fire;
   logic                 mul_wait;
   logic                 mul_start;
   logic                 mul_done;
   logic [XLEN-1:0]      mul_product;

   // RAM ports
   logic                 ram_wr_en;
   logic [IDXW-1:0]      ram_rd_addr_a;
   logic [IDXW-1:0]      ram_rd_addr_b;
   logic [XLEN-1:0]      ram_rd_data_a;
   logic [XLEN-1:0]      ram_rd_data_b;

   // Operands and execute results
   logic [XLEN-1:0]      op_a;
   logic [XLEN-1:0]      op_b;
   logic [XLEN-1:0]      exec_next_pc;
   logic [XLEN-1:0]      exec_value;
   rse_pkg::exec_flags_type flags;

   // Output register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [XLEN-1:0]      rsp_next_pc_ff;
   logic                 rsp_halted_ff;
   logic                 rsp_reg_written_ff;
   logic [4:0]           rsp_written_reg_ff;
   logic [XLEN-1:0]      rsp_written_value_ff;
   logic [XLEN-1:0]      rsp_return_value_ff;
   logic                 rsp_status_ff;

   function automatic logic [XLEN-1:0] read_operand(input logic [4:0] idx,
                                                     input logic [XLEN-1:0] ram_val);
      logic [XLEN-1:0] v;
      case (idx)
         rse_pkg::REG_ZERO: v = '0;
         rse_pkg::REG_RA:   v = ra_ff;
         rse_pkg::REG_A0:   v = arg_reg_ff[0];
         rse_pkg::REG_A1:   v = arg_reg_ff[1];
         rse_pkg::REG_A2:   v = arg_reg_ff[2];
         rse_pkg::REG_A3:   v = arg_reg_ff[3];
         default: begin
            if (fwd_valid_ff && (fwd_idx_ff == idx)) begin
               v = fwd_data_ff;
            end else if (!reg_valid_ff[idx[IDXW-1:0]]) begin
               v = '0;
            end else begin
               v = ram_val;
            end
         end
      endcase
      return v;
   endfunction

   // ---------------------------------------------------------------- handshake
   assign mul_wait  = flags.mul_op && !mul_done;
   assign mul_start = s1_valid_ff && mul_wait;
   assign s1_fire   = s1_valid_ff && !mul_wait && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire  = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s1_fire;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff   <= req_ch.cmd;
         s1_instr_ff <= req_ch.instr_word;
      end
   end

   // ---------------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         start_addr_ff <= '0;
         stop_addr_ff  <= '0;
         arg_cfg_ff    <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            rse_pkg::CFG_START_ADDRESS: start_addr_ff <= csr_wdata;
            rse_pkg::CFG_STOP_ADDRESS:  stop_addr_ff  <= csr_wdata;
            rse_pkg::CFG_ARG_ZERO:      arg_cfg_ff[0] <= csr_wdata;
            rse_pkg::CFG_ARG_ONE:       arg_cfg_ff[1] <= csr_wdata;
            rse_pkg::CFG_ARG_TWO:       arg_cfg_ff[2] <= csr_wdata;
            rse_pkg::CFG_ARG_THREE:     arg_cfg_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- register file
   // Re-read the held item's operands while it stalls
   assign ram_rd_addr_a = req_fire ? req_ch.instr_word[15 +: IDXW] : s1_instr_ff[15 +: IDXW];
   assign ram_rd_addr_b = req_fire ? req_ch.instr_word[20 +: IDXW] : s1_instr_ff[20 +: IDXW];
   assign ram_wr_en     = s1_fire && flags.write;

   rse_ram #(
      .WIDTH (XLEN),
      .DEPTH (REG_COUNT)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (flags.rd[IDXW-1:0]),
      .wr_data   (exec_value),
      .rd_addr_a (ram_rd_addr_a),
      .rd_data_a (ram_rd_data_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_b (ram_rd_data_b)
   );

   always_comb begin
      op_a = read_operand(s1_instr_ff[19:15], ram_rd_data_a);
   end

   always_comb begin
      op_b = read_operand(s1_instr_ff[24:20], ram_rd_data_b);
   end

   always_comb begin
      reg_valid_in = reg_valid_ff;
      if (ram_wr_en) begin
         reg_valid_in[flags.rd[IDXW-1:0]] = 1'b1;
      end
   end

   assign fwd_valid_in = ram_wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_valid_ff <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         reg_valid_ff <= reg_valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_idx_ff  <= flags.rd;
      fwd_data_ff <= exec_value;
   end

   // ---------------------------------------------------------------- execute
   rse_mul #(
      .XLEN (XLEN)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .clear   (s1_fire),
      .op_a    (op_a),
      .op_b    (op_b),
      .done    (mul_done),
      .product (mul_product)
   );

   rse_exec #(
      .XLEN      (XLEN),
      .REG_COUNT (REG_COUNT)
   ) u_exec (
      .cmd        (s1_cmd_ff),
      .instr_word (s1_instr_ff),
      .pc         (pc_ff),
      .start_pc   (start_addr_ff),
      .op_a       (op_a),
      .op_b       (op_b),
      .product    (mul_product),
      .next_pc    (exec_next_pc),
      .wr_value   (exec_value),
      .flags      (flags)
   );

   always_comb begin
      pc_in      = pc_ff;
      ra_in      = ra_ff;
      arg_reg_in = arg_reg_ff;
      if (s1_fire) begin
         if (flags.start) begin
            pc_in      = start_addr_ff;
            ra_in      = stop_addr_ff;
            arg_reg_in = arg_cfg_ff;
         end else if (!flags.bad) begin
            pc_in = exec_next_pc;
            if (flags.write) begin
               case (flags.rd)
                  rse_pkg::REG_RA: ra_in         = exec_value;
                  rse_pkg::REG_A0: arg_reg_in[0] = exec_value;
                  rse_pkg::REG_A1: arg_reg_in[1] = exec_value;
                  rse_pkg::REG_A2: arg_reg_in[2] = exec_value;
                  rse_pkg::REG_A3: arg_reg_in[3] = exec_value;
                  default: ;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= '0;
         ra_ff      <= '0;
         arg_reg_ff <= '0;
      end else begin
         pc_ff      <= pc_in;
         ra_ff      <= ra_in;
         arg_reg_ff <= arg_reg_in;
      end
   end

   // ---------------------------------------------------------------- result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_next_pc_ff       <= exec_next_pc;
         rsp_halted_ff        <= (exec_next_pc == stop_addr_ff);
         rsp_reg_written_ff   <= flags.write;
         rsp_written_reg_ff   <= flags.rd;
         rsp_written_value_ff <= exec_value;
         rsp_return_value_ff  <= arg_reg_in[0];
         rsp_status_ff        <= flags.bad ? rse_pkg::STATUS_BAD : rse_pkg::STATUS_OK;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.next_pc       = rsp_next_pc_ff;
   assign rsp_ch.halted        = rsp_halted_ff;
   assign rsp_ch.reg_written   = rsp_reg_written_ff;
   assign rsp_ch.written_reg   = rsp_written_reg_ff;
   assign rsp_ch.written_value = rsp_written_value_ff;
   assign rsp_ch.return_value  = rsp_return_value_ff;
   assign rsp_ch.status        = rsp_status_ff;

   // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
   a_mul_done_held: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> s1_valid_ff)
      else $error("multiplier result pending with no item in the execute stage");

   a_fwd_entry_valid: assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> reg_valid_ff[fwd_idx_ff[IDXW-1:0]])
      else $error("bypassed register not marked valid");

   a_x0_not_written: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_reg_written_ff && (rsp_written_reg_ff == rse_pkg::REG_ZERO)))
      else $error("result reports a write to x0");

   a_bad_keeps_pc: assert property (@(posedge clock) disable iff (reset)
      s1_fire && flags.bad |=> pc_ff == $past(pc_ff))
      else $error("rejected instruction changed the pc");
`endif

endmodule

// ----- sim/tb_riscv_subset_execute_top.sv -----
// Self-checking testbench for riscv_subset_execute_top: directed and random programs.

// Encodings the block does not own but the stimulus needs
localparam logic [6:0] OPC_LOAD = 7'h03;
localparam logic [2:0] F3_SLT   = 3'b010;
localparam logic [2:0] F3_JALR  = 3'b000;
localparam logic [6:0] F7_BASE  = 7'h00;
localparam logic [6:0] F7_SUB   = 7'h20;
localparam logic [6:0] F7_MUL   = 7'h01;

typedef struct packed {
   logic [63:0] next_pc;
   logic        halted;
   logic        reg_written;
   logic [4:0]  written_reg;
   logic [63:0] written_value;
   logic [63:0] return_value;
   logic        status;
} exec_result_type;

class retire_tracker;
   logic [63:0]     gpr [32];
   logic [63:0]     pc;
   logic [63:0]     csr_file [6];
   exec_result_type expected_retires [$];
   int              failures;

   function new();
      foreach (gpr[i]) gpr[i] = '0;
      foreach (csr_file[i]) csr_file[i] = '0;
      pc = '0;
      failures = 0;
   endfunction

   function void set_register(logic [2:0] idx, logic [63:0] value);
      csr_file[idx] = value;
   endfunction

   function int pending();
      return expected_retires.size();
   endfunction

   static function logic [63:0] shift_right_arith(logic [63:0] v, logic [5:0] sh);
      logic signed [63:0] s;
      s = v;
      return s >>> sh;
   endfunction

   // Architectural effect of one item on the register file and pc
   function exec_result_type execute_instruction(logic cmd, logic [31:0] iw);
      exec_result_type r;
      logic [6:0]  opc;
      logic [4:0]  rd, rs1, rs2;
      logic [2:0]  f3;
      logic [63:0] a, b, imm, boff, joff, npc, val;
      logic        wr, bad, taken;
      opc = iw[6:0];
      rd = iw[11:7];
      f3 = iw[14:12];
      rs1 = iw[19:15];
      rs2 = iw[24:20];
      wr = 1'b0;
      bad = 1'b0;
      taken = 1'b0;
      val = '0;
      if (cmd == rse_pkg::CMD_START) begin
         pc = csr_file[rse_pkg::CFG_START_ADDRESS];
         gpr[rse_pkg::REG_RA] = csr_file[rse_pkg::CFG_STOP_ADDRESS];
         gpr[rse_pkg::REG_A0] = csr_file[rse_pkg::CFG_ARG_ZERO];
         gpr[rse_pkg::REG_A1] = csr_file[rse_pkg::CFG_ARG_ONE];
         gpr[rse_pkg::REG_A2] = csr_file[rse_pkg::CFG_ARG_TWO];
         gpr[rse_pkg::REG_A3] = csr_file[rse_pkg::CFG_ARG_THREE];
         npc = pc;
         rd = rse_pkg::REG_ZERO;
      end else begin
         a = gpr[rs1];
         b = gpr[rs2];
         imm = {{52{iw[31]}}, iw[31:20]};
         boff = {{51{iw[31]}}, iw[31], iw[7], iw[30:25], iw[11:8], 1'b0};
         joff = {{43{iw[31]}}, iw[31], iw[19:12], iw[20], iw[30:21], 1'b0};
         npc = pc + 64'd4;
         case (opc)
            rse_pkg::OPC_OP: begin
               wr = 1'b1;
               case (f3)
                  rse_pkg::F3_ADD: val = iw[25] ? a * b : (iw[30] ? a - b : a + b);
                  rse_pkg::F3_SLL: val = a << b[5:0];
                  rse_pkg::F3_SRL: val = iw[30] ? shift_right_arith(a, b[5:0]) : a >> b[5:0];
                  rse_pkg::F3_AND: val = a & b;
                  default: bad = 1'b1;
               endcase
            end
            rse_pkg::OPC_IMM: begin
               wr = 1'b1;
               case (f3)
                  rse_pkg::F3_ADD: val = a + imm;
                  rse_pkg::F3_SLL: val = a << iw[25:20];
                  rse_pkg::F3_SRL: val = iw[30] ? shift_right_arith(a, iw[25:20])
                                                : a >> iw[25:20];
                  default: bad = 1'b1;
               endcase
            end
            rse_pkg::OPC_JALR: begin
               wr = 1'b1;
               val = pc + 64'd4;
               npc = (a + imm) & ~64'd1;
               if (f3 != F3_JALR) bad = 1'b1;
            end
            rse_pkg::OPC_BRANCH: begin
               case (f3)
                  rse_pkg::F3_BEQ: taken = (a == b);
                  rse_pkg::F3_BNE: taken = (a != b);
                  rse_pkg::F3_BLT: taken = ($signed(a) < $signed(b));
                  rse_pkg::F3_BGE: taken = !($signed(a) < $signed(b));
                  default: bad = 1'b1;
               endcase
               if (taken) npc = pc + boff;
               rd = rse_pkg::REG_ZERO;
            end
            rse_pkg::OPC_JAL: begin
               wr = 1'b1;
               val = pc + 64'd4;
               npc = pc + joff;
            end
            default: bad = 1'b1;
         endcase
         // Unsupported items leave every piece of state alone
         if (bad) begin
            npc = pc;
            wr = 1'b0;
         end else begin
            pc = npc;
            if (wr && rd != rse_pkg::REG_ZERO) gpr[rd] = val;
         end
      end
      if (!wr || rd == rse_pkg::REG_ZERO) begin
         wr = 1'b0;
         rd = rse_pkg::REG_ZERO;
         val = '0;
      end
      r.next_pc = npc;
      r.halted = (npc == csr_file[rse_pkg::CFG_STOP_ADDRESS]);
      r.reg_written = wr;
      r.written_reg = rd;
      r.written_value = val;
      r.return_value = gpr[rse_pkg::REG_A0];
      r.status = bad ? rse_pkg::STATUS_BAD : rse_pkg::STATUS_OK;
      return r;
   endfunction

   function void note_item(logic cmd, logic [31:0] iw);
      expected_retires.push_back(execute_instruction(cmd, iw));
   endfunction

   function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         failures++;
      end
   endfunction

   function void check_result(exec_result_type got);
      exec_result_type want;
      if (expected_retires.size() == 0) begin
         $error("result with no item outstanding: next_pc %h", got.next_pc);
         failures++;
         return;
      end
      want = expected_retires.pop_front();
      compare_field("next_pc", want.next_pc, got.next_pc);
      compare_field("halted", 64'(want.halted), 64'(got.halted));
      compare_field("reg_written", 64'(want.reg_written), 64'(got.reg_written));
      compare_field("written_reg", 64'(want.written_reg), 64'(got.written_reg));
      compare_field("written_value", want.written_value, got.written_value);
      compare_field("return_value", want.return_value, got.return_value);
      compare_field("status", 64'(want.status), 64'(got.status));
   endfunction
endclass

module tb_riscv_subset_execute_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TARGET_ITEMS   = 780;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 1000;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;
   logic        req_quiet;
   logic        rsp_quiet;
   int          items_sent;
   int          idle_cycles;

   retire_tracker book;

   rse_req_if req_bus ();
   rse_rsp_if #(.XLEN(64)) rsp_bus ();

   riscv_subset_execute_top #(
      .XLEN(64),
      .REG_COUNT(32)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int draw_gap(logic quiet);
      if (quiet) return 0;
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 18);
      return $urandom_range(0, 2);
   endfunction

   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, rse_pkg::OPC_OP};
   endfunction

   function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                         logic [4:0] rd, logic [6:0] opc);
      return {imm, rs1, f3, rd, opc};
   endfunction

   function automatic logic [31:0] enc_b(logic [12:0] off, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], rse_pkg::OPC_BRANCH};
   endfunction

   function automatic logic [31:0] enc_j(logic [20:0] off, logic [4:0] rd);
      return {off[20], off[10:1], off[11], off[19:12], rd, rse_pkg::OPC_JAL};
   endfunction

   // Favor x0 and the registers that start loads, so values flow between instructions
   function automatic logic [4:0] pick_reg();
      if ($urandom_range(0, 1) == 0) return 5'($urandom_range(0, 31));
      case ($urandom_range(0, 5))
         0: return rse_pkg::REG_ZERO;
         1: return rse_pkg::REG_RA;
         2: return rse_pkg::REG_A0;
         3: return rse_pkg::REG_A1;
         4: return rse_pkg::REG_A2;
         default: return rse_pkg::REG_A3;
      endcase
   endfunction

   function automatic logic [63:0] pick_wide();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         3: return 64'h7fff_ffff_ffff_ffff;
         4: return 64'($urandom_range(0, 64));
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic logic [31:0] random_instruction();
      logic [31:0] raw;
      logic [2:0]  f3;
      logic [6:0]  f7;
      int          k;
      raw = $urandom();
      k = $urandom_range(0, 99);
      if (k < 8) return raw;
      if (k < 14) begin
         // valid major opcode with random fields, funct3 often unsupported
         case ($urandom_range(0, 3))
            0: return {raw[31:7], rse_pkg::OPC_OP};
            1: return {raw[31:7], rse_pkg::OPC_IMM};
            2: return {raw[31:7], rse_pkg::OPC_JALR};
            default: return {raw[31:7], rse_pkg::OPC_BRANCH};
         endcase
      end
      if (k < 42) begin
         case ($urandom_range(0, 6))
            0: begin f3 = rse_pkg::F3_ADD; f7 = F7_BASE; end
            1: begin f3 = rse_pkg::F3_ADD; f7 = F7_SUB; end
            2: begin f3 = rse_pkg::F3_ADD; f7 = F7_MUL; end
            3: begin f3 = rse_pkg::F3_SLL; f7 = F7_BASE; end
            4: begin f3 = rse_pkg::F3_SRL; f7 = F7_BASE; end
            5: begin f3 = rse_pkg::F3_SRL; f7 = F7_SUB; end
            default: begin f3 = rse_pkg::F3_AND; f7 = F7_BASE; end
         endcase
         // flip funct7 bits the decoder ignores
         if ($urandom_range(0, 9) == 0) f7 = f7 ^ {raw[31], 1'b0, raw[29:26], 1'b0};
         return enc_r(f7, pick_reg(), pick_reg(), f3, pick_reg());
      end
      if (k < 68) begin
         case ($urandom_range(0, 3))
            0: return enc_i(raw[31:20], pick_reg(), rse_pkg::F3_ADD, pick_reg(),
                            rse_pkg::OPC_IMM);
            1: return enc_i({F7_BASE[6:1], raw[25:20]}, pick_reg(), rse_pkg::F3_SLL,
                            pick_reg(), rse_pkg::OPC_IMM);
            2: return enc_i({F7_BASE[6:1], raw[25:20]}, pick_reg(), rse_pkg::F3_SRL,
                            pick_reg(), rse_pkg::OPC_IMM);
            default: return enc_i({F7_SUB[6:1], raw[25:20]}, pick_reg(), rse_pkg::F3_SRL,
                                  pick_reg(), rse_pkg::OPC_IMM);
         endcase
      end
      if (k < 80) begin
         case ($urandom_range(0, 3))
            0: f3 = rse_pkg::F3_BEQ;
            1: f3 = rse_pkg::F3_BNE;
            2: f3 = rse_pkg::F3_BLT;
            default: f3 = rse_pkg::F3_BGE;
         endcase
         return enc_b(raw[12:0], pick_reg(), pick_reg(), f3);
      end
      if (k < 88) return enc_j(raw[20:0], pick_reg());
      return enc_i(raw[31:20], pick_reg(), F3_JALR, pick_reg(), rse_pkg::OPC_JALR);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(logic cmd, logic [31:0] word);
      int gap;
      gap = draw_gap(req_quiet);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.instr_word <= word;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (book.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [63:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      book.set_register(idx, value);
   endtask

   task automatic load_config(logic [63:0] start_pc, logic [63:0] stop_pc, logic [63:0] a0,
                              logic [63:0] a1, logic [63:0] a2, logic [63:0] a3);
      write_csr(rse_pkg::CFG_START_ADDRESS, start_pc);
      write_csr(rse_pkg::CFG_STOP_ADDRESS, stop_pc);
      write_csr(rse_pkg::CFG_ARG_ZERO, a0);
      write_csr(rse_pkg::CFG_ARG_ONE, a1);
      write_csr(rse_pkg::CFG_ARG_TWO, a2);
      write_csr(rse_pkg::CFG_ARG_THREE, a3);
      csr_write_en <= 1'b0;
   endtask

   task automatic directed_programs();
      wait_drained();
      // start and stop at their maximum: start lands on the stop address, pc wraps
      load_config('1, '1, '1, '1, 64'h8000_0000_0000_0000, 64'd63);
      send_item(rse_pkg::CMD_START, 32'h0);
      send_item(rse_pkg::CMD_EXECUTE,
                enc_r(F7_BASE, rse_pkg::REG_A1, rse_pkg::REG_A0, rse_pkg::F3_ADD, 5'd5));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_r(F7_SUB, rse_pkg::REG_A0, rse_pkg::REG_ZERO, rse_pkg::F3_ADD, 5'd6));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_r(F7_MUL, rse_pkg::REG_A2, rse_pkg::REG_A0, rse_pkg::F3_ADD, 5'd7));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_r(F7_BASE, rse_pkg::REG_A3, rse_pkg::REG_A0, rse_pkg::F3_SLL, 5'd8));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_r(F7_BASE, rse_pkg::REG_A3, rse_pkg::REG_A0, rse_pkg::F3_SRL, 5'd9));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_r(F7_SUB, rse_pkg::REG_A3, rse_pkg::REG_A2, rse_pkg::F3_SRL, 5'd14));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_r(F7_BASE, 5'd6, rse_pkg::REG_A0, rse_pkg::F3_AND, 5'd15));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_i(12'h800, rse_pkg::REG_ZERO, rse_pkg::F3_ADD, 5'd16, rse_pkg::OPC_IMM));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_i(12'h7ff, 5'd16, rse_pkg::F3_ADD, 5'd17, rse_pkg::OPC_IMM));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_i({F7_BASE[6:1], 6'd63}, rse_pkg::REG_A0, rse_pkg::F3_SLL, 5'd18,
                      rse_pkg::OPC_IMM));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_i({F7_BASE[6:1], 6'd63}, rse_pkg::REG_A0, rse_pkg::F3_SRL, 5'd19,
                      rse_pkg::OPC_IMM));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_i({F7_SUB[6:1], 6'd5}, 5'd16, rse_pkg::F3_SRL, 5'd20, rse_pkg::OPC_IMM));
      // write to x0 is dropped
      send_item(rse_pkg::CMD_EXECUTE,
                enc_r(F7_BASE, rse_pkg::REG_A1, rse_pkg::REG_A0, rse_pkg::F3_ADD,
                      rse_pkg::REG_ZERO));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_b(13'h1ffc, rse_pkg::REG_A1, rse_pkg::REG_A0, rse_pkg::F3_BEQ));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_b(13'd8, rse_pkg::REG_A1, rse_pkg::REG_A0, rse_pkg::F3_BNE));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_b(13'h1000, rse_pkg::REG_ZERO, 5'd16, rse_pkg::F3_BLT));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_b(13'h0ffe, 5'd16, rse_pkg::REG_ZERO, rse_pkg::F3_BGE));
      send_item(rse_pkg::CMD_EXECUTE, enc_j(21'h100000, 5'd21));
      send_item(rse_pkg::CMD_EXECUTE, enc_j(21'h0ffffe, rse_pkg::REG_A0));
      // unsupported encodings, state must hold; the last item is a valid jalr with target bit 0 cleared
      send_item(rse_pkg::CMD_EXECUTE, enc_i(12'd0, rse_pkg::REG_A0, F3_SLT, 5'd5, OPC_LOAD));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_r(F7_BASE, rse_pkg::REG_RA, rse_pkg::REG_A0, F3_SLT, 5'd3));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_i(12'hfff, rse_pkg::REG_A0, rse_pkg::F3_AND, 5'd4, rse_pkg::OPC_IMM));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_i(12'd0, rse_pkg::REG_RA, rse_pkg::F3_SLL, 5'd5, rse_pkg::OPC_JALR));
      send_item(rse_pkg::CMD_EXECUTE, enc_b(13'd8, rse_pkg::REG_RA, rse_pkg::REG_A1, F3_SLT));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_i(12'hfff, rse_pkg::REG_ZERO, F3_JALR, 5'd22, rse_pkg::OPC_JALR));

      wait_drained();
      // everything at zero: return through ra halts
      load_config('0, '0, '0, '0, '0, '0);
      send_item(rse_pkg::CMD_START, 32'hffff_ffff);
      send_item(rse_pkg::CMD_EXECUTE,
                enc_i(12'd1, rse_pkg::REG_A0, rse_pkg::F3_ADD, rse_pkg::REG_A0,
                      rse_pkg::OPC_IMM));
      send_item(rse_pkg::CMD_EXECUTE, enc_j(21'd0, rse_pkg::REG_ZERO));
      send_item(rse_pkg::CMD_EXECUTE,
                enc_i(12'd0, rse_pkg::REG_RA, F3_JALR, rse_pkg::REG_ZERO, rse_pkg::OPC_JALR));
   endtask

   task automatic random_program();
      logic [63:0] start_pc;
      logic [63:0] stop_pc;
      int          n;
      int          k;
      wait_drained();
      req_quiet = ($urandom_range(0, 3) == 0);
      rsp_quiet = ($urandom_range(0, 3) == 0);
      start_pc = pick_wide();
      stop_pc = ($urandom_range(0, 7) == 0) ? start_pc : pick_wide();
      // keep stop even most of the time so a return can land on it
      if ($urandom_range(0, 3) != 0) stop_pc[0] = 1'b0;
      load_config(start_pc, stop_pc, pick_wide(), pick_wide(), pick_wide(), pick_wide());
      send_item(rse_pkg::CMD_START, $urandom());
      n = $urandom_range(10, 60);
      repeat (n) begin
         k = $urandom_range(0, 99);
         if (k < 2) send_item(rse_pkg::CMD_START, $urandom());
         else if (k < 5)
            send_item(rse_pkg::CMD_EXECUTE,
                      enc_i(12'd0, rse_pkg::REG_RA, F3_JALR, rse_pkg::REG_ZERO,
                            rse_pkg::OPC_JALR));
         else send_item(rse_pkg::CMD_EXECUTE, random_instruction());
      end
      if ($urandom_range(0, 1) == 0)
         send_item(rse_pkg::CMD_EXECUTE,
                   enc_i(12'd0, rse_pkg::REG_RA, F3_JALR, rse_pkg::REG_ZERO,
                         rse_pkg::OPC_JALR));
   endtask

   // Stimulus and end of run
   initial begin
      book = new();
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.cmd = rse_pkg::CMD_START;
      req_bus.instr_word = '0;
      rsp_bus.ready = 1'b0;
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      items_sent = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      directed_programs();
      while (items_sent < TARGET_ITEMS) random_program();
      req_bus.valid <= 1'b0;
      while (book.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (book.failures == 0 && book.pending() == 0) $display("PASS riscv_subset_execute_top");
      else $display("FAIL riscv_subset_execute_top");
      $finish;
   end

   // Result side: stall a random number of cycles before each transfer
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = draw_gap(rsp_quiet);
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         @(negedge clock);
      end
   end

   // Monitor both channels and watch for a hang
   always @(posedge clock) begin
      exec_result_type got;
      logic            moved;
      moved = 1'b0;
      if (reset !== 1'b1) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.next_pc = rsp_bus.next_pc;
            got.halted = rsp_bus.halted;
            got.reg_written = rsp_bus.reg_written;
            got.written_reg = rsp_bus.written_reg;
            got.written_value = rsp_bus.written_value;
            got.return_value = rsp_bus.return_value;
            got.status = rsp_bus.status;
            book.check_result(got);
            moved = 1'b1;
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            book.note_item(req_bus.cmd, req_bus.instr_word);
            moved = 1'b1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL riscv_subset_execute_top");
            $finish;
         end
      end else begin
         idle_cycles = 0;
      end
   end

endmodule

// ----- filelist.f -----
design/rse_pkg.sv
design/rse_if.sv
design/rse_ram.sv
design/rse_mul.sv
design/rse_exec.sv
design/riscv_subset_execute_top.sv
sim/tb_riscv_subset_execute_top.sv
